@@ hdl/b64sc_pkg.sv @@
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, character constants and alphabet mapping functions shared by the
// base64 stream codec modules.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  // One input item: a raw byte (encode) or an ASCII character (decode)
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  // Work handed from the front end to the back end: up to four results.
  // Entry 0 goes out first. A job with no bytes and last set is a bare end mark.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      num;
    logic            last;
  } job_t;

  // Mode register values
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Character constants
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  // Number of results in a job
  localparam logic [2:0] NUM_NONE  = 3'd0;
  localparam logic [2:0] NUM_ONE   = 3'd1;
  localparam logic [2:0] NUM_TWO   = 3'd2;
  localparam logic [2:0] NUM_THREE = 3'd3;
  localparam logic [2:0] NUM_FOUR  = 3'd4;

  // Sextet to alphabet character
  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < 6'd26)       return 8'd65 + w;           // 'A'..'Z'
    else if (s < 6'd52)  return 8'd97 + w - 8'd26;   // 'a'..'z'
    else if (s < 6'd62)  return 8'd48 + w - 8'd52;   // '0'..'9'
    else if (s == 6'd62) return 8'h2B;               // '+'
    else                 return 8'h2F;               // '/'
  endfunction

  // Character to sextet; bit 6 set marks a character outside the alphabet
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      return {1'b0, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      return {1'b0, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      return {1'b0, d[5:0]};
    end else if (c == 8'h2B) begin
      return 7'd62;
    end else if (c == 8'h2F) begin
      return 7'd63;
    end else begin
      return 7'h40;
    end
  endfunction

endpackage

@@ hdl/b64sc_front.sv @@
// ----------------------------------------------------------------------------
// b64sc_front
// Accepts input items, keeps the group state and turns each item into a job
// of zero to four results for the back end.
// ----------------------------------------------------------------------------
module b64sc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_take,
  input  b64sc_pkg::in_item_t in_item,
  output logic               job_push,
  output b64sc_pkg::job_t    job
);
  import b64sc_pkg::*;

  logic        mode_r;
  logic [23:0] group_bits_r, group_bits_nxt;
  logic [1:0]  group_count_r, group_count_nxt;
  logic        stopped_r, stopped_nxt;
  logic        leading_r, leading_nxt;

  // Classify the item and work out the job and next state
  always_comb begin
    logic [7:0]  b;
    logic [1:0]  cm;
    logic [23:0] g;
    logic [6:0]  sx;
    logic [2:0]  cnt3;

    b    = in_item.in_byte;
    cm   = 2'd0;
    g    = group_bits_r;
    sx   = char_to_sextet(b);
    cnt3 = {1'b0, group_count_r} + 3'd1;

    group_bits_nxt  = group_bits_r;
    group_count_nxt = group_count_r;
    stopped_nxt     = stopped_r;
    leading_nxt     = leading_r;
    job.chars       = '0;
    job.num         = NUM_NONE;
    job.last        = in_item.in_last;

    if (mode_r == MODE_ENCODE) begin
      // byte slot within the group of three
      cm = (group_count_r == 2'd3) ? 2'd0 : group_count_r;
      case (cm)
        2'd0:    g[23:16] = g[23:16] | b;
        2'd1:    g[15:8]  = g[15:8]  | b;
        default: g[7:0]   = g[7:0]   | b;
      endcase
      if (cm == 2'd2 || in_item.in_last) begin
        job.chars[0] = sextet_to_char(g[23:18]);
        job.chars[1] = sextet_to_char(g[17:12]);
        job.chars[2] = (cm == 2'd0) ? CHAR_PAD : sextet_to_char(g[11:6]);
        job.chars[3] = (cm != 2'd2) ? CHAR_PAD : sextet_to_char(g[5:0]);
        job.num         = NUM_FOUR;
        group_bits_nxt  = '0;
        group_count_nxt = 2'd0;
      end else begin
        group_bits_nxt  = g;
        group_count_nxt = cm + 2'd1;
      end
    end else if (!stopped_r) begin
      if (leading_r && (b == CHAR_SPACE || b == CHAR_TAB)) begin
        // leading white space is skipped
      end else begin
        leading_nxt = 1'b0;
        if (!sx[6]) begin
          case (group_count_r)
            2'd0:    g[23:18] = g[23:18] | sx[5:0];
            2'd1:    g[17:12] = g[17:12] | sx[5:0];
            2'd2:    g[11:6]  = g[11:6]  | sx[5:0];
            default: g[5:0]   = g[5:0]   | sx[5:0];
          endcase
          if (group_count_r == 2'd3) begin
            job.chars[0]    = g[23:16];
            job.chars[1]    = g[15:8];
            job.chars[2]    = g[7:0];
            job.num         = NUM_THREE;
            group_bits_nxt  = '0;
            group_count_nxt = 2'd0;
          end else begin
            group_bits_nxt  = g;
            group_count_nxt = cnt3[1:0];
          end
        end else begin
          // stop character: flush the partial group
          job.chars[0]    = g[23:16];
          job.chars[1]    = g[15:8];
          job.num         = (group_count_r == 2'd3) ? NUM_TWO :
                            (group_count_r == 2'd2) ? NUM_ONE : NUM_NONE;
          stopped_nxt     = 1'b1;
          group_bits_nxt  = '0;
          group_count_nxt = 2'd0;
        end
      end
    end

    // end of message returns to the start state
    if (in_item.in_last) begin
      group_bits_nxt  = '0;
      group_count_nxt = 2'd0;
      stopped_nxt     = 1'b0;
      leading_nxt     = 1'b1;
    end
  end

  assign job_push = in_take && (job.num != NUM_NONE || job.last);

  // State registers; a mode write restarts the message
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_ENCODE;
      group_bits_r  <= '0;
      group_count_r <= 2'd0;
      stopped_r     <= 1'b0;
      leading_r     <= 1'b1;
    end else if (cfg_wr_en) begin
      mode_r        <= cfg_wr_data;
      group_bits_r  <= '0;
      group_count_r <= 2'd0;
      stopped_r     <= 1'b0;
      leading_r     <= 1'b1;
    end else if (in_take) begin
      group_bits_r  <= group_bits_nxt;
      group_count_r <= group_count_nxt;
      stopped_r     <= stopped_nxt;
      leading_r     <= leading_nxt;
    end
  end

  // Encode groups hold at most two bytes between transfers
  a_enc_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_ENCODE |-> group_count_r != 2'd3)
    else $error("encode group count out of range");

  // A final item leaves the message state at its start
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_item.in_last |=> group_count_r == 2'd0 && leading_r && !stopped_r)
    else $error("message state not cleared after last item");

  // Nothing is gathered once decoding has stopped
  a_stopped_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> group_count_r == 2'd0 && group_bits_r == 24'd0)
    else $error("group state held after stop character");

endmodule

@@ hdl/b64sc_jobq.sv @@
// ----------------------------------------------------------------------------
// b64sc_jobq
// Small FIFO of jobs between the front end and the back end. DEPTH must be a
// power of two, two or more.
// ----------------------------------------------------------------------------
module b64sc_jobq #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  b64sc_pkg::job_t wr_data,
  input  logic            rd_en,
  output b64sc_pkg::job_t rd_data,
  output logic            full,
  output logic            empty
);
  import b64sc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count; pointers wrap at the power-of-two depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_rd) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (do_wr && !do_rd)      count_r <= count_r + CNT_W'(1);
      else if (do_rd && !do_wr) count_r <= count_r - CNT_W'(1);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("job queue count exceeds depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> PTR_W'(wr_ptr_r - rd_ptr_r) == count_r[PTR_W-1:0])
    else $error("job queue pointers disagree with count");

  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    do_wr && !do_rd |=> !empty)
    else $error("job queue lost a write");

endmodule

@@ hdl/b64sc_back.sv @@
// ----------------------------------------------------------------------------
// b64sc_back
// Steps through the job at the head of the queue and presents one result per
// transfer, with the end mark on the final result of a message.
// ----------------------------------------------------------------------------
module b64sc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  b64sc_pkg::job_t      head,
  input  logic                 q_empty,
  output logic                 q_rd,
  input  logic                 pop,
  output logic                 empty,
  output b64sc_pkg::out_item_t out_item
);
  import b64sc_pkg::*;

  logic [1:0] idx_r;
  logic [1:0] last_idx;
  logic       at_end;
  logic       take;
  logic [2:0] num_m1;

  assign num_m1   = head.num - 3'd1;
  assign last_idx = (head.num == NUM_NONE) ? 2'd0 : num_m1[1:0];
  assign at_end   = (idx_r == last_idx);
  assign empty    = q_empty;
  assign take     = pop && !q_empty;
  assign q_rd     = take && at_end;

  // Result fields from the head job
  always_comb begin
    out_item.out_valid = (head.num != NUM_NONE);
    out_item.out_byte  = out_item.out_valid ? head.chars[idx_r] : 8'd0;
    out_item.out_last  = head.last && at_end;
  end

  // Position within the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (take) begin
      idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r <= last_idx)
    else $error("result index beyond job");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> idx_r == 2'd0)
    else $error("result index not at start with no job");

  a_job_done: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> head.last == out_item.out_last)
    else $error("end mark not on final result of job");

endmodule

@@ hdl/base64_stream_codec.sv @@
// ----------------------------------------------------------------------------
// base64_stream_codec
// Standard-alphabet base64 encoder/decoder, one byte per input transfer.
//
//   Channel  Ports                        Transfer when
//   input    in_item, push, full          push && !full
//   result   out_item, empty, pop         pop && !empty
//   config   cfg_wr_en, cfg_wr_data       cfg_wr_en (mode; restarts message)
//
// An input transfer is classified in the cycle it is taken and queued as a
// job; the first result can be popped the next cycle. The back end gives one
// result per cycle while pop is high and a job is queued, so the result side
// sets the rate: 4 results per 3 bytes encoded, 3 per 4 characters decoded.
// full rises when JOBQ_DEPTH jobs wait; empty is low while a job is queued.
// Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module base64_stream_codec #(
  parameter int JOBQ_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  b64sc_pkg::in_item_t  in_item,
  input  logic                 push,
  output logic                 full,
  output b64sc_pkg::out_item_t out_item,
  output logic                 empty,
  input  logic                 pop
);
  import b64sc_pkg::*;

  logic in_take;
  logic job_push;
  job_t job;
  job_t head;
  logic q_rd;
  logic q_empty;

  assign in_take = push && !full;

  // Front end: classify input transfers into jobs
  b64sc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_take    (in_take),
    .in_item    (in_item),
    .job_push   (job_push),
    .job        (job)
  );

  // Job queue between the two ends
  b64sc_jobq #(
    .DEPTH(JOBQ_DEPTH)
  ) u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_data(job),
    .rd_en  (q_rd),
    .rd_data(head),
    .full   (full),
    .empty  (q_empty)
  );

  // Back end: one result per transfer
  b64sc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .out_item(out_item)
  );

endmodule

@@ dv/tb_base64_stream_codec.sv @@
// ----------------------------------------------------------------------------
// tb_base64_stream_codec
// Self-checking bench for the base64 stream codec. A scoreboard class keeps
// its own model of the encoder/decoder state and predicts every result from
// each input transfer. Directed messages cover padding, leading blanks, stop
// characters and bare end marks. Random messages then run in alternating
// modes, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_base64_stream_codec;
  import b64sc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 48;
  localparam int NUM_PHASES   = 8;
  localparam int SETTLE_TICKS = 6;

  // Predicts codec results and checks them in order
  class codec_scoreboard;
    string       alphabet;
    logic        mode;
    logic [23:0] grp_bits;
    int          grp_cnt;
    bit          stopped;
    bit          leading;
    out_item_t   due[$];
    int          faults;

    function new();
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      mode     = MODE_ENCODE;
      faults   = 0;
      clear_msg();
    endfunction

    function void clear_msg();
      grp_bits = '0;
      grp_cnt  = 0;
      stopped  = 1'b0;
      leading  = 1'b1;
    endfunction

    // Mode write restarts the message
    function void set_mode(logic m);
      mode = m;
      clear_msg();
    endfunction

    function logic [7:0] char_of(logic [5:0] s);
      return alphabet[s];
    endfunction

    // Bit 6 set: not in the alphabet
    function logic [6:0] sextet_of(logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
        if (alphabet[i] == c) return i[6:0];
      end
      return 7'h40;
    endfunction

    // Notes one input transfer and queues the results it causes
    function void take_input(in_item_t it);
      out_item_t   r[4];
      int          n;
      logic [6:0]  sx;
      logic [23:0] g;
      n = 0;
      if (mode == MODE_ENCODE) begin
        grp_bits = grp_bits | ({16'd0, it.in_byte} << (16 - 8 * grp_cnt));
        grp_cnt++;
        if (grp_cnt == 3 || it.in_last) begin
          g    = grp_bits;
          r[0] = '{char_of(g[23:18]), 1'b1, 1'b0};
          r[1] = '{char_of(g[17:12]), 1'b1, 1'b0};
          r[2] = '{(grp_cnt < 2) ? CHAR_PAD : char_of(g[11:6]), 1'b1, 1'b0};
          r[3] = '{(grp_cnt < 3) ? CHAR_PAD : char_of(g[5:0]), 1'b1, 1'b0};
          n        = 4;
          grp_bits = '0;
          grp_cnt  = 0;
        end
      end else if (!stopped &&
                   !(leading && (it.in_byte == CHAR_SPACE || it.in_byte == CHAR_TAB))) begin
        leading = 1'b0;
        sx      = sextet_of(it.in_byte);
        g       = grp_bits;
        if (!sx[6]) begin
          g = g | ({18'd0, sx[5:0]} << (18 - 6 * grp_cnt));
          grp_cnt++;
          if (grp_cnt == 4) begin
            r[0]    = '{g[23:16], 1'b1, 1'b0};
            r[1]    = '{g[15:8], 1'b1, 1'b0};
            r[2]    = '{g[7:0], 1'b1, 1'b0};
            n       = 3;
            g       = '0;
            grp_cnt = 0;
          end
          grp_bits = g;
        end else begin
          // stop character: flush whatever whole bytes are gathered
          stopped = 1'b1;
          if (grp_cnt >= 2) begin
            r[n] = '{g[23:16], 1'b1, 1'b0};
            n++;
          end
          if (grp_cnt == 3) begin
            r[n] = '{g[15:8], 1'b1, 1'b0};
            n++;
          end
          grp_bits = '0;
          grp_cnt  = 0;
        end
      end
      // end of message: tag the final result, or add a bare end mark
      if (it.in_last) begin
        if (n > 0) begin
          r[n-1].out_last = 1'b1;
        end else begin
          r[0] = '{8'h00, 1'b0, 1'b1};
          n    = 1;
        end
        clear_msg();
      end
      for (int i = 0; i < n; i++) due = {due, r[i]};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        faults++;
        $display("%0t: result with nothing due: byte=%02h valid=%0b last=%0b",
                 $time, got.out_byte, got.out_valid, got.out_last);
        return;
      end
      want = due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        faults++;
        $display("%0t: out_byte expected %02h actual %02h", $time,
                 want.out_byte, got.out_byte);
      end
      if (got.out_valid !== want.out_valid) begin
        faults++;
        $display("%0t: out_valid expected %0b actual %0b", $time,
                 want.out_valid, got.out_valid);
      end
      if (got.out_last !== want.out_last) begin
        faults++;
        $display("%0t: out_last expected %0b actual %0b", $time,
                 want.out_last, got.out_last);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;
  in_item_t  in_item = '0;
  logic      push = 1'b0;
  logic      full;
  out_item_t out_item;
  logic      empty;
  logic      pop = 1'b0;

  codec_scoreboard sb;
  in_item_t        msg_q[$];
  int              sent;
  int              burst_left = 0;
  bit              calm = 1'b0;
  int              rx_style = 0;
  int              rx_tick = 0;
  int              stall_left = 0;
  int              cycles = 0;

  base64_stream_codec uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .push        (push),
    .full        (full),
    .out_item    (out_item),
    .empty       (empty),
    .pop         (pop)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("base64_stream_codec: mismatch");
      $finish;
    end
  end

  // Result side: check each transfer, then pick pop for the next cycle
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_item);
    rx_tick++;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      case (rx_style)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= (rx_tick % 3 == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(2, 6);
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
          end
        end
      endcase
    end
  end

  function automatic in_item_t mk(logic [7:0] b, logic l);
    in_item_t r;
    r.in_byte = b;
    r.in_last = l;
    return r;
  endfunction

  // Append one item to the message being built
  function automatic void add_item(in_item_t it);
    msg_q = {msg_q, it};
  endfunction

  // Bursts of random length separated by random gaps
  function automatic int next_gap();
    if (calm) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 12);
    return $urandom_range(1, 8);
  endfunction

  // One input transfer; push only drops for a gap
  task automatic send_item(in_item_t it, int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= it;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    sb.take_input(it);
    sent++;
  endtask

  // Send the built message; a non-zero budget may cut it short
  task automatic send_msg(int budget);
    foreach (msg_q[i]) begin
      if (budget > 0 && sent >= budget) break;
      send_item(msg_q[i], next_gap());
    end
  endtask

  // Wait until every due result is in, then idle as slack
  task automatic settle();
    push <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_wr_data <= m;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    sb.set_mode(m);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic mark_end();
    in_item_t t;
    t = msg_q.pop_back();
    t.in_last = 1'b1;
    add_item(t);
  endtask

  task automatic make_bytes();
    msg_q.delete();
    repeat ($urandom_range(1, 10)) add_item(mk(8'($urandom_range(0, 255)), 1'b0));
    mark_end();
  endtask

  // Mostly well-formed text with varied endings; some pure noise
  task automatic make_text();
    int tail;
    msg_q.delete();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3))
        add_item(mk($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB, 1'b0));
    end
    repeat ($urandom_range(0, 11))
      add_item(mk(sb.char_of(6'($urandom_range(0, 63))), 1'b0));
    tail = $urandom_range(0, 9);
    if (tail == 4 || tail == 5) begin
      repeat ($urandom_range(1, 2)) add_item(mk(CHAR_PAD, 1'b0));
    end else if (tail == 6) begin
      add_item(mk($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB, 1'b0));
    end else if (tail == 7) begin
      add_item(mk(8'($urandom_range(0, 255)), 1'b0));
    end else if (tail == 8) begin
      msg_q.delete();
      repeat ($urandom_range(1, 6)) add_item(mk(8'($urandom_range(0, 255)), 1'b0));
    end else if (tail == 9) begin
      // junk after a stop character
      add_item(mk(CHAR_PAD, 1'b0));
      repeat ($urandom_range(1, 3)) add_item(mk(8'($urandom_range(0, 255)), 1'b0));
    end
    if (msg_q.size() == 0) add_item(mk(sb.char_of(6'($urandom_range(0, 63))), 1'b0));
    mark_end();
  endtask

  initial begin
    logic m;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Encode, reset mode: one-byte, two-byte and full groups, extreme bytes
    msg_q = '{mk(8'h00, 1'b1),
              mk(8'hFF, 1'b0), mk(8'hFF, 1'b1),
              mk(8'hFB, 1'b0), mk(8'hEF, 1'b0), mk(8'hBE, 1'b0), mk(8'h7F, 1'b1)};
    send_msg(0);
    settle();

    // Decode: leading blanks, '=' stop, high-bit stop, blank after start,
    // lone blank with the end flag
    write_mode(MODE_DECODE);
    msg_q = '{mk(CHAR_SPACE, 1'b0), mk(CHAR_TAB, 1'b0),
              mk("T", 1'b0), mk("W", 1'b0), mk("F", 1'b0), mk("u", 1'b1),
              mk("T", 1'b0), mk("Q", 1'b0), mk(CHAR_PAD, 1'b0), mk(CHAR_PAD, 1'b1),
              mk("T", 1'b0), mk("W", 1'b0), mk("E", 1'b0), mk(8'hFF, 1'b1),
              mk("T", 1'b0), mk(CHAR_SPACE, 1'b0), mk("A", 1'b1),
              mk(CHAR_SPACE, 1'b1)};
    send_msg(0);
    settle();

    // Random phases in alternating modes; a phase may end mid-message
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      m = (ph % 2 == 0) ? MODE_ENCODE : MODE_DECODE;
      write_mode(m);
      calm     = (ph == 3 || ph == 6);
      rx_style = $urandom_range(0, 3);
      sent     = 0;
      while (sent < PHASE_ITEMS) begin
        if (m == MODE_ENCODE) make_bytes();
        else make_text();
        send_msg(PHASE_ITEMS);
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.faults == 0 && sb.due.size() == 0) begin
      $display("base64_stream_codec: match");
    end else begin
      $display("base64_stream_codec: mismatch");
    end
    $finish;
  end

endmodule
